FILE: hw/rtl/ies_pkg.sv
package ies_pkg;

  localparam int unsigned MAX_EDGES_DEF = 32;
  localparam int unsigned ADDR_BITS_DEF = 48;
  localparam int unsigned OUT_ADDR_BITS = 48;
  localparam int unsigned LIST_LIMIT    = 16;

  typedef enum logic [1:0] {
    MODE_MARK   = 2'd0,
    MODE_UNMARK = 2'd1,
    MODE_LIST   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_ODD   = 2'd3
  } status_t;

endpackage

FILE: hw/rtl/ies_ram.sv
module ies_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/interval_edge_set_core.sv
// clear and rejected ranges go from the accepting state straight to the result state;
// list reads each region through S_LIST_RD, S_LIST_A and S_LIST_B, and an empty table
// or the odd-count result goes from S_LIST_RD to the result; an edit walks the table
// and writes a new copy, paced by the single read and write port of each table bank
// one transaction at a time: in_tready is low until the last result has been taken
// rst_n (synchronous, active low) empties the table and idles the sequencer; contents kept
module interval_edge_set_core #(
  parameter int unsigned MAX_EDGES = ies_pkg::MAX_EDGES_DEF,
  parameter int unsigned ADDR_BITS = ies_pkg::ADDR_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // mode[1:0], range_start[49:2], range_end[97:50], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // status[1:0], region_valid[2], region_start[50:3],
                                   // region_end[98:51], zero pad
  output logic         out_tlast
);

  localparam int unsigned IW = $clog2(MAX_EDGES);
  localparam int unsigned CW = $clog2(MAX_EDGES + 3);
  localparam int unsigned OA = ies_pkg::OUT_ADDR_BITS;
  localparam int unsigned LW = $clog2(ies_pkg::LIST_LIMIT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_EMIT_A, S_EMIT_B, S_COPY_RD, S_COPY_WR,
    S_LIST_RD, S_LIST_A, S_LIST_B, S_OUT, S_DONE
  } state_t;

  // two banks; bank_r holds the live copy, an edit writes the other
  state_t               state_r;
  logic                 bank_r;
  logic [CW-1:0]        count_r, n_r, rd_r;
  logic [ADDR_BITS-1:0] start_r, end_r, val_r;
  logic                 marked_r, phase_r;
  logic [LW-1:0]        nout_r;
  logic [1:0]           status_r;
  logic                 rv_r, last_r;
  logic [OA-1:0]        rs_r, re_r;

  logic [ADDR_BITS-1:0] rdata0, rdata1, rdata, wdata;
  logic [IW-1:0]        raddr, waddr;
  logic                 we0, we1;
  logic                 wr_en;

  assign rdata = bank_r ? rdata1 : rdata0;
  // while the region start is captured, the end edge is already being read
  assign raddr = (state_r == S_LIST_A) ? IW'(rd_r + 1'b1) : rd_r[IW-1:0];
  assign waddr = n_r[IW-1:0];
  assign we0   = wr_en & bank_r;
  assign we1   = wr_en & ~bank_r;

  ies_ram #(.WIDTH(ADDR_BITS), .DEPTH(MAX_EDGES)) u_ram0 (
    .clk, .we(we0), .waddr, .wdata, .raddr, .rdata(rdata0)
  );
  ies_ram #(.WIDTH(ADDR_BITS), .DEPTH(MAX_EDGES)) u_ram1 (
    .clk, .we(we1), .waddr, .wdata, .raddr, .rdata(rdata1)
  );

  logic [1:0] in_mode;
  logic [ADDR_BITS-1:0] in_s, in_e;
  logic [63:0] s64, e64;
  assign in_mode = in_tdata[1:0];
  assign s64 = 64'(in_tdata[49:2]);
  assign e64 = 64'(in_tdata[97:50]);
  assign in_s = s64[ADDR_BITS-1:0];
  assign in_e = e64[ADDR_BITS-1:0];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {5'd0, re_r, rs_r, rv_r, status_r};
  assign out_tlast  = last_r;

  // scan compare: phase 0 finds first edge >= start, phase 1 first edge > end
  logic in_cnt, stop;
  logic [ADDR_BITS+OA-1:0] ext;
  assign in_cnt = (rd_r < count_r);
  assign stop   = !in_cnt || (phase_r ? (rdata > end_r) : (rdata >= start_r));
  assign ext    = {{OA{1'b0}}, rdata};

  always_comb begin
    wr_en = 1'b0;
    wdata = val_r;
    case (state_r)
      S_EMIT_A: begin wr_en = (n_r[0] != marked_r); wdata = start_r; end
      S_EMIT_B: begin wr_en = 1'b0; end
      S_COPY_WR: begin
        wr_en = (n_r < CW'(MAX_EDGES));
        wdata = phase_r ? rdata : val_r;
      end
      S_SCAN_CHK: begin
        wr_en = !phase_r && !stop && (n_r < CW'(MAX_EDGES));
        wdata = rdata;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bank_r  <= 1'b0;
      count_r <= '0;
      last_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          start_r  <= in_s;
          end_r    <= in_e;
          marked_r <= (in_mode == ies_pkg::MODE_MARK);
          rd_r     <= '0;
          n_r      <= '0;
          phase_r  <= 1'b0;
          nout_r   <= '0;
          rv_r     <= 1'b0;
          rs_r     <= '0;
          re_r     <= '0;
          status_r <= ies_pkg::ST_OK;
          last_r   <= 1'b1;
          case (in_mode)
            ies_pkg::MODE_CLEAR: begin count_r <= '0; state_r <= S_OUT; end
            ies_pkg::MODE_LIST: state_r <= S_LIST_RD;
            default: begin
              if (in_s >= in_e) begin
                status_r <= ies_pkg::ST_RANGE;
                state_r  <= S_OUT;
              end else begin
                state_r <= S_SCAN_RD;
              end
            end
          endcase
        end
        S_SCAN_RD: state_r <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (stop) begin
            if (!phase_r) state_r <= S_EMIT_A;
            else state_r <= S_EMIT_B;
          end else begin
            rd_r <= rd_r + 1'b1;
            if (!phase_r) n_r <= n_r + 1'b1;
            state_r <= S_SCAN_RD;
          end
        end
        S_EMIT_A: begin
          // i == n here; parity of i decides whether start is an edge
          if (rd_r[0] != marked_r) n_r <= n_r + 1'b1;
          phase_r <= 1'b1;
          state_r <= S_SCAN_RD;
        end
        S_EMIT_B: begin
          // end edge written in copy state through val_r
          if (rd_r[0] != marked_r) begin
            val_r   <= end_r;
            state_r <= S_COPY_WR;
            phase_r <= 1'b0;
          end else begin
            state_r <= S_COPY_RD;
          end
          if (32'(n_r) + 32'(rd_r[0] != marked_r) + 32'(count_r) - 32'(rd_r)
              > MAX_EDGES) begin
            status_r <= ies_pkg::ST_FULL;
            state_r  <= S_OUT;
          end
        end
        S_COPY_RD: begin
          if (rd_r < count_r) begin
            phase_r <= 1'b1;
            state_r <= S_COPY_WR;
          end else begin
            count_r <= n_r;
            bank_r  <= ~bank_r;
            state_r <= S_OUT;
          end
        end
        S_COPY_WR: begin
          // phase 0 writes the pending end edge, phase 1 a copied edge
          n_r <= n_r + 1'b1;
          if (phase_r) rd_r <= rd_r + 1'b1;
          state_r <= S_COPY_RD;
        end
        S_LIST_RD: begin
          if (rd_r + 1'b1 < count_r && nout_r < LW'(ies_pkg::LIST_LIMIT)) begin
            state_r <= S_LIST_A;
          end else if (count_r[0] && nout_r < LW'(ies_pkg::LIST_LIMIT)) begin
            status_r <= ies_pkg::ST_ODD;
            rv_r <= 1'b0; rs_r <= '0; re_r <= '0;
            last_r <= 1'b1;
            state_r <= S_OUT;
          end else begin
            // nothing more; only reached with no results emitted
            status_r <= ies_pkg::ST_OK;
            rv_r <= 1'b0; rs_r <= '0; re_r <= '0;
            last_r <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_LIST_A: begin
          rs_r    <= ext[OA-1:0];
          rd_r    <= rd_r + 1'b1;
          state_r <= S_LIST_B;
        end
        S_LIST_B: begin
          re_r   <= ext[OA-1:0];
          rv_r   <= 1'b1;
          rd_r   <= rd_r + 1'b1;
          nout_r <= nout_r + 1'b1;
          last_r <= !((rd_r + 2'd2 < count_r || count_r[0]) &&
                      nout_r + 1'b1 < LW'(ies_pkg::LIST_LIMIT));
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) begin
          if (last_r) state_r <= S_IDLE;
          else state_r <= S_LIST_RD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_EDGES)) else $error("edge count above table size");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && rv_r |-> status_r == ies_pkg::ST_OK) else $error("bad region status");
`endif

endmodule

FILE: bench/interval_edge_set_core_tb.sv
`timescale 1ns / 100ps

module interval_edge_set_core_tb;

  localparam int unsigned N_EDGES = ies_pkg::MAX_EDGES_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    ies_pkg::status_t status;
    logic             region_valid;
    logic [47:0]      region_start;
    logic [47:0]      region_end;
    logic             last;
  } region_rsp_t;

  typedef struct {
    ies_pkg::mode_t mode;
    logic [47:0]    lo;
    logic [47:0]    hi;
    logic           has_rsp;
    region_rsp_t    rsp;
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic         out_tlast;

  interval_edge_set_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // predictor copy of the edge table
  logic [47:0] edge_tbl [N_EDGES];
  int unsigned edge_num;
  region_rsp_t rsp_queue[$];

  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_recv;
  int unsigned quiet_cycles;
  bit          timed_out;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic region_rsp_t mk_rsp(ies_pkg::status_t st, logic v, logic [47:0] s,
                                         logic [47:0] e, logic l);
    region_rsp_t r;
    r.status = st;
    r.region_valid = v;
    r.region_start = s;
    r.region_end = e;
    r.last = l;
    return r;
  endfunction

  function automatic ies_pkg::status_t apply_edit(logic [47:0] lo, logic [47:0] hi,
                                                  bit marked);
    logic [47:0] merged [N_EDGES + 2];
    int unsigned n;
    int unsigned i;
    int unsigned j;
    n = 0;
    i = 0;
    while (i < edge_num && edge_tbl[i] < lo) i++;
    for (int unsigned k = 0; k < i; k++) merged[n++] = edge_tbl[k];
    if (i[0] != marked) merged[n++] = lo;
    j = i;
    while (j < edge_num && edge_tbl[j] <= hi) j++;
    if (j[0] != marked) merged[n++] = hi;
    if (n + (edge_num - j) > N_EDGES) return ies_pkg::ST_FULL;
    for (int unsigned k = j; k < edge_num; k++) merged[n++] = edge_tbl[k];
    for (int unsigned k = 0; k < n; k++) edge_tbl[k] = merged[k];
    edge_num = n;
    return ies_pkg::ST_OK;
  endfunction

  function automatic void predict_regions(ies_pkg::mode_t mode, logic [47:0] lo,
                                          logic [47:0] hi);
    int unsigned k;
    k = 0;
    case (mode)
      ies_pkg::MODE_CLEAR: begin
        edge_num = 0;
        rsp_queue.push_back(mk_rsp(ies_pkg::ST_OK, 1'b0, '0, '0, 1'b1));
      end
      ies_pkg::MODE_LIST: begin
        for (int unsigned i = 0; i + 1 < edge_num && k < ies_pkg::LIST_LIMIT; i += 2) begin
          rsp_queue.push_back(mk_rsp(ies_pkg::ST_OK, 1'b1, edge_tbl[i], edge_tbl[i + 1],
                                     1'b0));
          k++;
        end
        if (edge_num[0] && k < ies_pkg::LIST_LIMIT) begin
          rsp_queue.push_back(mk_rsp(ies_pkg::ST_ODD, 1'b0, '0, '0, 1'b0));
          k++;
        end
        if (k == 0) rsp_queue.push_back(mk_rsp(ies_pkg::ST_OK, 1'b0, '0, '0, 1'b1));
        else rsp_queue[$].last = 1'b1;
      end
      default: begin
        if (lo >= hi) rsp_queue.push_back(mk_rsp(ies_pkg::ST_RANGE, 1'b0, '0, '0, 1'b1));
        else rsp_queue.push_back(mk_rsp(apply_edit(lo, hi, mode == ies_pkg::MODE_MARK),
                                        1'b0, '0, '0, 1'b1));
      end
    endcase
  endfunction

  // response checker
  always @(posedge clk) begin
    region_rsp_t got;
    region_rsp_t exp_rsp;
    if (rst_n && out_tvalid && out_tready) begin
      got = mk_rsp(ies_pkg::status_t'(out_tdata[1:0]), out_tdata[2], out_tdata[50:3],
                   out_tdata[98:51], out_tlast);
      if (rsp_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected transaction: %p", got);
      end else begin
        exp_rsp = rsp_queue.pop_front();
        if (got !== exp_rsp) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p, got %p", exp_rsp, got);
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // tvalid stays up after a transaction until the next idle cycle or drain
  task automatic send_region_op(ies_pkg::mode_t mode, logic [47:0] lo, logic [47:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, hi, lo, mode};
    do @(posedge clk); while (!in_tready);
    predict_regions(mode, lo, hi);
  endtask

  function automatic logic [47:0] rand_addr(bit narrow);
    if (narrow) return 48'($urandom_range(255));
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic send_random_op();
    int unsigned pick;
    logic [47:0] a;
    logic [47:0] b;
    bit narrow;
    ies_pkg::mode_t mode;
    pick = $urandom_range(99);
    narrow = $urandom_range(3) != 0;
    a = rand_addr(narrow);
    b = rand_addr(narrow);
    if (pick < 40) mode = ies_pkg::MODE_MARK;
    else if (pick < 75) mode = ies_pkg::MODE_UNMARK;
    else if (pick < 95) mode = ies_pkg::MODE_LIST;
    else mode = ies_pkg::MODE_CLEAR;
    // mostly well-formed ranges
    if ($urandom_range(9) != 0 && a > b) send_region_op(mode, b, a);
    else send_region_op(mode, a, b);
  endtask

  task automatic drain_regions();
    in_tvalid <= 1'b0;
    while (rsp_queue.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  localparam logic [47:0] ADDR_TOP = 48'hFFFF_FFFF_FFFF;

  stim_row_t dir_rows[$];

  function automatic void add_row(ies_pkg::mode_t m, logic [47:0] lo, logic [47:0] hi,
                                  logic has, region_rsp_t r);
    stim_row_t s;
    s.mode = m;
    s.lo = lo;
    s.hi = hi;
    s.has_rsp = has;
    s.rsp = r;
    dir_rows.push_back(s);
  endfunction

  initial begin
    region_rsp_t none;
    none = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    hold_recv = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    timed_out = 1'b0;
    edge_num = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(ies_pkg::MODE_LIST, '0, '0, 1'b1,
            mk_rsp(ies_pkg::ST_OK, 1'b0, '0, '0, 1'b1));
    add_row(ies_pkg::MODE_MARK, 48'd5, 48'd5, 1'b1,
            mk_rsp(ies_pkg::ST_RANGE, 1'b0, '0, '0, 1'b1));
    add_row(ies_pkg::MODE_UNMARK, ADDR_TOP, '0, 1'b1,
            mk_rsp(ies_pkg::ST_RANGE, 1'b0, '0, '0, 1'b1));
    add_row(ies_pkg::MODE_MARK, '0, ADDR_TOP, 1'b1,
            mk_rsp(ies_pkg::ST_OK, 1'b0, '0, '0, 1'b1));
    add_row(ies_pkg::MODE_LIST, '0, '0, 1'b1,
            mk_rsp(ies_pkg::ST_OK, 1'b1, '0, ADDR_TOP, 1'b1));
    add_row(ies_pkg::MODE_UNMARK, 48'd100, 48'd200, 1'b0, none);
    add_row(ies_pkg::MODE_MARK, 48'd150, 48'd160, 1'b0, none);
    add_row(ies_pkg::MODE_MARK, 48'd200, 48'd300, 1'b0, none);
    add_row(ies_pkg::MODE_UNMARK, '0, 48'd1, 1'b0, none);
    add_row(ies_pkg::MODE_MARK, 48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAB, 1'b0, none);
    add_row(ies_pkg::MODE_UNMARK, 48'h5555_5555_5555, 48'hFFFF_FFFF_FFFE, 1'b0, none);
    add_row(ies_pkg::MODE_LIST, '0, '0, 1'b0, none);
    add_row(ies_pkg::MODE_CLEAR, '0, '0, 1'b1,
            mk_rsp(ies_pkg::ST_OK, 1'b0, '0, '0, 1'b1));
    add_row(ies_pkg::MODE_UNMARK, 48'd10, 48'd20, 1'b0, none);
    add_row(ies_pkg::MODE_LIST, ADDR_TOP, ADDR_TOP, 1'b1,
            mk_rsp(ies_pkg::ST_OK, 1'b0, '0, '0, 1'b1));

    // directed part; typed rows hold the block to the typed value
    foreach (dir_rows[r]) begin
      send_region_op(dir_rows[r].mode, dir_rows[r].lo, dir_rows[r].hi);
      if (dir_rows[r].has_rsp) begin
        if (rsp_queue[$] !== dir_rows[r].rsp) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("row %0d: expected %p, predicted %p", r, dir_rows[r].rsp, rsp_queue[$]);
        end
        rsp_queue[$] = dir_rows[r].rsp;
        drain_regions();
      end
    end
    drain_regions();

    // fill the table: sixteen regions then overflow, list hits the limit
    for (int unsigned k = 0; k < 17; k++)
      send_region_op(ies_pkg::MODE_MARK, 48'(10 * k + 1000), 48'(10 * k + 1005));
    send_region_op(ies_pkg::MODE_LIST, '0, '0);
    send_region_op(ies_pkg::MODE_CLEAR, '0, '0);
    for (int unsigned k = 0; k < 20; k++)
      send_region_op(ies_pkg::MODE_MARK, 48'(10 * k), 48'(10 * k + 3));
    send_region_op(ies_pkg::MODE_LIST, '0, '0);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      repeat (8) send_region_op(ies_pkg::MODE_LIST, '0, '0);
    join
    drain_regions();

    send_idle_pct = 25;
    recv_idle_pct = 75;
    repeat (120) send_random_op();
    send_idle_pct = 75;
    recv_idle_pct = 25;
    repeat (120) send_random_op();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (105) send_random_op();
    drain_regions();

    if (mismatch_count == 0 && rsp_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
